@@ rtl/esc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the sensor compensation block.
// Used by every module under rtl; depends on nothing else.
package esc_pkg;

  typedef logic signed [31:0] s32_t;

  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 56;
  localparam int unsigned QueueDepthDf = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTemp   = 3'd0,
    CfgPressA = 3'd1,
    CfgPressB = 3'd2,
    CfgPressC = 3'd3,
    CfgHumA   = 3'd4,
    CfgHumB   = 3'd5
  } cfg_idx_e;

  localparam s32_t PressOffset = 32'sd64000;
  localparam s32_t PressFull   = 32'sd1048576;
  localparam s32_t PressScale  = 32'sd3125;
  localparam s32_t PressLimit  = 32'sd1073741824;
  localparam s32_t DivBase     = 32'sd32768;
  localparam s32_t TempRound   = 32'sd128;
  localparam s32_t HumScale    = 32'sd1000;
  localparam s32_t HumBias     = 32'sd16384;
  localparam s32_t PressMax    = 32'sd262143;
  localparam s32_t HumMax      = 32'sd100000;

  // x / 100 == (x * Div100Magic) >> 37 for every 32-bit unsigned x
  localparam logic [63:0] Div100Magic = 64'd1374389535;

  // calibration words, each extended to the datapath width
  typedef struct packed {
    s32_t t1; s32_t t2; s32_t t3;
    s32_t p1; s32_t p2; s32_t p3; s32_t p4; s32_t p5;
    s32_t p6; s32_t p7; s32_t p8; s32_t p9; s32_t p10;
    s32_t h1; s32_t h2; s32_t h3; s32_t h4; s32_t h5; s32_t h6; s32_t h7;
  } cal_t;

  typedef struct packed {
    logic [15:0] rh;
    logic [19:0] rp;
    logic [19:0] rt;
  } in_item_t;

  // handed from front to back through the queue
  typedef struct packed {
    s32_t        tf;
    logic [19:0] rp;
    logic [15:0] ct_sat;
    logic [16:0] hm;
  } mid_item_t;

  typedef struct packed {
    logic        fault;
    logic [16:0] hm;
    logic [17:0] pc;
    logic [15:0] ct;
  } out_item_t;

  function automatic logic [31:0] abs32(input s32_t x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic s32_t div100_q(input logic [63:0] p);
    return s32_t'({5'b0, p[63:37]});
  endfunction

endpackage

@@ rtl/esc_front.sv @@
// Front pipeline: accepts raw triples, derives fine temperature, temperature and humidity.
// Depends on esc_pkg.
module esc_front import esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cal_t      cal_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mid_item_t out_data_o
);

  localparam int unsigned NStage = 21;

  typedef struct packed {
    logic [19:0] rp;
    logic [15:0] rh;
    s32_t        tf;
    s32_t        ct;
    s32_t        x1;
    s32_t        x4;
    s32_t        d4;
  } fcarry_t;

  logic [NStage-1:0] v_q;
  logic              en;
  fcarry_t           cr_q [NStage];
  fcarry_t           cr_d [NStage];

  s32_t        a_q, m1_q, sq_q, b_q, m2_q;
  s32_t        hp_q [4];
  logic [31:0] mag_q [4];
  logic [3:0]  sg_q, sg8_q;
  logic [63:0] pr_q [4];
  s32_t        dq_q [4];
  s32_t        m55_q, d55_q, x2s_q, x2m_q, x3_q, x3a_q, x3b_q, x5m_q, x6m_q, hs_q, hmm_q;
  logic [31:0] mg_q;
  logic        sgm_q, sgm2_q;
  logic [63:0] prm_q;
  logic [15:0] ctsat_q;
  logic [16:0] hm_q;
  s32_t        hm_sh;

  assign en         = !v_q[NStage-1] || out_ready_i;
  assign in_ready_o = en;
  assign hm_sh      = hmm_q >>> 12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStage-2:0], in_valid_i};
    end
  end

  // advance the carried fields and fill in the ones computed at each stage
  always_comb begin
    for (int k = 1; k < NStage; k++) begin
      cr_d[k] = cr_q[k-1];
    end
    cr_d[0]    = '0;
    cr_d[0].rp = in_data_i.rp;
    cr_d[0].rh = in_data_i.rh;
    cr_d[3].tf = b_q + (m2_q >>> 14);
    cr_d[4].ct = ((cr_q[3].tf <<< 2) + cr_q[3].tf + TempRound) >>> 8;
    cr_d[9].x1 = s32_t'({16'b0, cr_q[8].rh}) - (cal_i.h1 <<< 4) - (dq_q[0] >>> 1);
    cr_d[9].x4 = ((cal_i.h6 <<< 7) + dq_q[3]) >>> 4;
    cr_d[9].d4 = dq_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NStage; k++) begin
        cr_q[k] <= cr_d[k];
      end
      // temperature
      a_q  <= (s32_t'({12'b0, in_data_i.rt}) >>> 3) - (cal_i.t1 <<< 1);
      m1_q <= a_q * cal_i.t2;
      sq_q <= (a_q >>> 1) * (a_q >>> 1);
      b_q  <= m1_q >>> 11;
      m2_q <= (sq_q >>> 12) * (cal_i.t3 <<< 4);
      // humidity: four products of the temperature, each divided by 100
      hp_q[0] <= cr_q[4].ct * cal_i.h3;
      hp_q[1] <= cr_q[4].ct * cal_i.h4;
      hp_q[2] <= cr_q[4].ct * cal_i.h5;
      hp_q[3] <= cr_q[4].ct * cal_i.h7;
      for (int i = 0; i < 4; i++) begin
        mag_q[i] <= abs32(hp_q[i]);
        sg_q[i]  <= hp_q[i][31];
        pr_q[i]  <= 64'(mag_q[i]) * Div100Magic;
        dq_q[i]  <= sg8_q[i] ? -div100_q(pr_q[i]) : div100_q(pr_q[i]);
      end
      sg8_q <= sg_q;
      m55_q <= cr_q[8].ct * dq_q[2];
      mg_q   <= abs32(m55_q >>> 6);
      sgm_q  <= m55_q[31];
      prm_q  <= 64'(mg_q) * Div100Magic;
      sgm2_q <= sgm_q;
      d55_q  <= sgm2_q ? -div100_q(prm_q) : div100_q(prm_q);
      x2s_q  <= cr_q[12].d4 + d55_q + HumBias;
      x2m_q  <= cal_i.h2 * x2s_q;
      x3_q   <= cr_q[14].x1 * (x2m_q >>> 10);
      x5m_q  <= (x3_q >>> 14) * (x3_q >>> 14);
      x3a_q  <= x3_q;
      x6m_q  <= cr_q[16].x4 * (x5m_q >>> 10);
      x3b_q  <= x3a_q;
      hs_q   <= (x3b_q + (x6m_q >>> 1)) >>> 10;
      hmm_q  <= hs_q * HumScale;
      // final stage: saturate
      if (hm_sh < 0) begin
        hm_q <= '0;
      end else if (hm_sh > HumMax) begin
        hm_q <= 17'(HumMax);
      end else begin
        hm_q <= hm_sh[16:0];
      end
      if (cr_q[19].ct < -32'sd32768) begin
        ctsat_q <= 16'h8000;
      end else if (cr_q[19].ct > 32'sd32767) begin
        ctsat_q <= 16'h7fff;
      end else begin
        ctsat_q <= cr_q[19].ct[15:0];
      end
    end
  end

  assign out_valid_o       = v_q[NStage-1];
  assign out_data_o.tf     = cr_q[NStage-1].tf;
  assign out_data_o.rp     = cr_q[NStage-1].rp;
  assign out_data_o.ct_sat = ctsat_q;
  assign out_data_o.hm     = hm_q;

endmodule

@@ rtl/esc_queue.sv @@
// Short queue between front and back pipelines so each side stalls on its own.
// Depends on esc_pkg.
module esc_queue import esc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDf
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mid_item_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mid_item_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mid_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != CntW'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count beyond depth");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_ptr_q == rd_ptr_q) else $error("queue pointers apart while empty");
`endif

endmodule

@@ rtl/esc_back.sv @@
// Back pipeline: pressure polynomial with a bit-per-stage divider and the output register.
// Depends on esc_pkg.
module esc_back import esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cal_t      cal_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mid_item_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned DivBits = 32;
  localparam int unsigned NPre    = 5;
  localparam int unsigned NPost   = 6;
  localparam int unsigned NStage  = NPre + 1 + DivBits + NPost;

  typedef struct packed {
    logic [19:0] rp;
    logic [15:0] ct;
    logic [16:0] hm;
  } bcarry_t;

  typedef struct packed {
    logic [15:0] ct;
    logic [16:0] hm;
    logic        fault;
  } pcarry_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic        neg;
    logic        big;
    logic        fault;
    logic [15:0] ct;
    logic [16:0] hm;
  } div_t;

  function automatic div_t div_step(input div_t s);
    div_t        r;
    logic [32:0] t;
    logic        qb;
    r  = s;
    t  = {s.rem, s.num[31]};
    qb = t >= {1'b0, s.den};
    r.rem = qb ? 32'(t - {1'b0, s.den}) : t[31:0];
    r.num = {s.num[30:0], qb};
    return r;
  endfunction

  logic [NStage-1:0] v_q;
  logic              en;
  bcarry_t           bc_q [NPre];
  pcarry_t           pk_q [NPost];
  div_t              dv_q [DivBits+1];

  s32_t a_q, qq_q, m5_q, m2_q, ba_q, ca_q, m5b_q, m2b_q, bb_q, cc_q, cm_q, pm_q;
  s32_t c_w, n_w, q_w;
  s32_t pc0_q, pc1_q, pc2_q, pc3_q, pc4_q;
  s32_t ss_q, em_q, rr_q, r_q, dm_q, rrr_q, em2_q, d_q, fm_q, e_q, sum_q, pcn_w;
  logic        big_w;
  logic [17:0] pc_q;

  assign en         = !v_q[NStage-1] || out_ready_i;
  assign in_ready_o = en;

  assign c_w   = cm_q >>> 15;
  assign big_w = pm_q >= PressLimit;
  assign n_w   = big_w ? pm_q : (pm_q <<< 1);
  assign q_w   = dv_q[DivBits].neg ? -s32_t'(dv_q[DivBits].num) : s32_t'(dv_q[DivBits].num);
  assign pcn_w = pc4_q + (sum_q >>> 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStage-2:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 1; k < NPre; k++) begin
        bc_q[k] <= bc_q[k-1];
      end
      for (int k = 1; k < NPost; k++) begin
        pk_q[k] <= pk_q[k-1];
      end
      bc_q[0] <= '{rp: in_data_i.rp, ct: in_data_i.ct_sat, hm: in_data_i.hm};
      a_q   <= (in_data_i.tf >>> 1) - PressOffset;
      qq_q  <= (a_q >>> 2) * (a_q >>> 2);
      m5_q  <= a_q * cal_i.p5;
      m2_q  <= cal_i.p2 * a_q;
      ba_q  <= (qq_q >>> 11) * cal_i.p6;
      ca_q  <= (qq_q >>> 13) * (cal_i.p3 <<< 5);
      m5b_q <= m5_q;
      m2b_q <= m2_q;
      bb_q  <= ((((ba_q >>> 2) + (m5b_q <<< 1)) >>> 2) + (cal_i.p4 <<< 16));
      cc_q  <= ((ca_q >>> 3) + (m2b_q >>> 1)) >>> 18;
      cm_q  <= (DivBase + cc_q) * cal_i.p1;
      pm_q  <= ((PressFull - s32_t'({12'b0, bc_q[3].rp})) - (bb_q >>> 12)) * PressScale;
      // divider setup on magnitudes
      dv_q[0].rem   <= '0;
      dv_q[0].num   <= abs32(n_w);
      dv_q[0].den   <= abs32(c_w);
      dv_q[0].neg   <= n_w[31] ^ c_w[31];
      dv_q[0].big   <= big_w;
      dv_q[0].fault <= c_w == '0;
      dv_q[0].ct    <= bc_q[NPre-1].ct;
      dv_q[0].hm    <= bc_q[NPre-1].hm;
      // correction terms
      pk_q[0] <= '{ct: dv_q[DivBits].ct, hm: dv_q[DivBits].hm, fault: dv_q[DivBits].fault};
      pc0_q <= dv_q[DivBits].big ? (q_w <<< 1) : q_w;
      ss_q  <= (pc0_q >>> 3) * (pc0_q >>> 3);
      em_q  <= (pc0_q >>> 2) * cal_i.p8;
      rr_q  <= (pc0_q >>> 8) * (pc0_q >>> 8);
      r_q   <= pc0_q >>> 8;
      pc1_q <= pc0_q;
      dm_q  <= cal_i.p9 * (ss_q >>> 13);
      rrr_q <= rr_q * r_q;
      em2_q <= em_q;
      pc2_q <= pc1_q;
      d_q   <= dm_q >>> 12;
      fm_q  <= rrr_q * cal_i.p10;
      e_q   <= em2_q >>> 13;
      pc3_q <= pc2_q;
      sum_q <= d_q + e_q + (fm_q >>> 17) + (cal_i.p7 <<< 7);
      pc4_q <= pc3_q;
      if (pk_q[NPost-2].fault || pcn_w < 0) begin
        pc_q <= '0;
      end else if (pcn_w > PressMax) begin
        pc_q <= 18'(PressMax);
      end else begin
        pc_q <= pcn_w[17:0];
      end
    end
  end

  assign out_valid_o      = v_q[NStage-1];
  assign out_data_o.fault = pk_q[NPost-1].fault;
  assign out_data_o.hm    = pk_q[NPost-1].hm;
  assign out_data_o.pc    = pc_q;
  assign out_data_o.ct    = pk_q[NPost-1].ct;

endmodule

@@ rtl/env_sensor_compensation.sv @@
// Environmental sensor compensation: temperature, pressure and humidity from raw counts.
// Holds the calibration registers and joins front pipeline, queue and back pipeline.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
//
// Usage: write the six calibration registers through cfg_we_i / cfg_index_i /
// cfg_wdata_i while no measurement is in flight. Raw triples enter on the s_axis
// channel; each gives one compensated result on the m_axis channel, in order.
// One transfer per cycle in each direction when neither side stalls. A result
// passes through 21 front stages (temperature and humidity), the queue, and 44
// back stages, 32 of them one quotient bit each of the pressure divider. When
// the receiver stalls, the back pipeline holds, the queue fills, and then the
// front drops s_axis_tready. Reset clears all calibration words to zero and
// empties every stage and the queue.
module env_sensor_compensation import esc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDf
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // raw_temperature [19:0], raw_pressure [39:20], raw_humidity [55:40]
  input  logic [55:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // temperature_centi [15:0], pressure_pa [33:16], humidity_milli [50:34], zero [55:51]
  output logic [55:0]         m_axis_tdata,
  // divide_fault [0]
  output logic [0:0]          m_axis_tuser
);

  logic [39:0] temp_cal_q, hum_cal_a_q;
  logic [55:0] press_cal_a_q;
  logic [47:0] press_cal_b_q;
  logic [23:0] press_cal_c_q, hum_cal_b_q;
  cal_t        cal;

  logic      q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  mid_item_t q_in_data, q_out_data;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q    <= '0;
      press_cal_a_q <= '0;
      press_cal_b_q <= '0;
      press_cal_c_q <= '0;
      hum_cal_a_q   <= '0;
      hum_cal_b_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTemp:   temp_cal_q    <= cfg_wdata_i[39:0];
        CfgPressA: press_cal_a_q <= cfg_wdata_i;
        CfgPressB: press_cal_b_q <= cfg_wdata_i[47:0];
        CfgPressC: press_cal_c_q <= cfg_wdata_i[23:0];
        CfgHumA:   hum_cal_a_q   <= cfg_wdata_i[39:0];
        CfgHumB:   hum_cal_b_q   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign cal.t1  = s32_t'({16'b0, temp_cal_q[15:0]});
  assign cal.t2  = s32_t'(signed'(temp_cal_q[31:16]));
  assign cal.t3  = s32_t'(signed'(temp_cal_q[39:32]));
  assign cal.p1  = s32_t'({16'b0, press_cal_a_q[15:0]});
  assign cal.p2  = s32_t'(signed'(press_cal_a_q[31:16]));
  assign cal.p3  = s32_t'(signed'(press_cal_a_q[39:32]));
  assign cal.p4  = s32_t'(signed'(press_cal_a_q[55:40]));
  assign cal.p5  = s32_t'(signed'(press_cal_b_q[15:0]));
  assign cal.p6  = s32_t'(signed'(press_cal_b_q[23:16]));
  assign cal.p7  = s32_t'(signed'(press_cal_b_q[31:24]));
  assign cal.p8  = s32_t'(signed'(press_cal_b_q[47:32]));
  assign cal.p9  = s32_t'(signed'(press_cal_c_q[15:0]));
  assign cal.p10 = s32_t'({24'b0, press_cal_c_q[23:16]});
  assign cal.h1  = s32_t'({20'b0, hum_cal_a_q[11:0]});
  assign cal.h2  = s32_t'({20'b0, hum_cal_a_q[23:12]});
  assign cal.h3  = s32_t'(signed'(hum_cal_a_q[31:24]));
  assign cal.h4  = s32_t'(signed'(hum_cal_a_q[39:32]));
  assign cal.h5  = s32_t'(signed'(hum_cal_b_q[7:0]));
  assign cal.h6  = s32_t'({24'b0, hum_cal_b_q[15:8]});
  assign cal.h7  = s32_t'(signed'(hum_cal_b_q[23:16]));

  esc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_item_t'(s_axis_tdata)),
    .out_valid_o (q_in_valid),
    .out_ready_i (q_in_ready),
    .out_data_o  (q_in_data)
  );

  esc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_in_valid),
    .in_ready_o  (q_in_ready),
    .in_data_i   (q_in_data),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_data_o  (q_out_data)
  );

  esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (q_out_valid),
    .in_ready_o  (q_out_ready),
    .in_data_i   (q_out_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {5'b0, res.hm, res.pc, res.ct};
  assign m_axis_tuser = res.fault;

`ifndef ASSERT_OFF
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[33:16] == '0)
    else $error("pressure not forced to zero on divide fault");
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[50:34] <= 17'd100000)
    else $error("humidity beyond clamp");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:51] == '0)
    else $error("output padding not zero");
`endif

endmodule
